/* sv/bbc_pkg.sv */
`default_nettype none
package bbc_pkg;

	localparam int STACK_DEPTH_DEF = 64;

	// bracket characters
	localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5b;
	localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7b;
	localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5d;
	localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7d;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_MISMATCH = 2'd1,
		STATUS_UNCLOSED = 2'd2,
		STATUS_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2
	} op_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_of_string;
	} in_item_t;

	typedef struct packed {
		logic    is_valid;
		status_t status;
	} out_item_t;

	// classified character passed from front to back
	typedef struct packed {
		op_t   op;
		kind_t kind;
		logic  last;
	} op_item_t;

endpackage
`default_nettype wire

/* sv/bracket_balance_checker_core.sv */
// the request carrying the last character passes the front queue, then the verdict register;
//   classified requests still queued ahead of it are handled first
// throughput: one character per cycle while verdicts are taken as they come
// the back end stalls only when a last character meets a full, unread output register
// reset: arst_n clears queue, stack level, error and output valid; no clearing pass,
// stack entries are written before they are read
`default_nettype none
module bracket_balance_checker_core #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire bbc_pkg::in_item_t  req_data,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output bbc_pkg::out_item_t      rsp_data
);
	import bbc_pkg::*;

	// classified characters between front and back
	logic     q_valid;
	logic     q_ready;
	op_item_t q_data;

	// front: decode brackets into push / pop / ignore, two-entry queue
	bbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data)
	);

	// back: stack with registered top, ram below it, sticky first error,
	// verdict register toward the response side
	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule
`default_nettype wire

/* sv/bbc_ram.sv */
`default_nettype none
module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* sv/bbc_front.sv */
`default_nettype none
module bbc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire bbc_pkg::in_item_t req_data,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output bbc_pkg::op_item_t      q_data
);
	import bbc_pkg::*;

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);

	op_item_t          cls;
	op_item_t          slot_q [QDEPTH];
	logic [QPW-1:0]    wptr_q;
	logic [QPW-1:0]    rptr_q;
	logic [QPW:0]      cnt_q;
	logic              wr_en;
	logic              rd_en;

	// character classification
	always_comb begin
		cls.op   = OP_NONE;
		cls.kind = KIND_ROUND;
		cls.last = req_data.last_of_string;
		case (req_data.char_code)
			CHAR_OPEN_ROUND: begin
				cls.op   = OP_PUSH;
				cls.kind = KIND_ROUND;
			end
			CHAR_OPEN_SQUARE: begin
				cls.op   = OP_PUSH;
				cls.kind = KIND_SQUARE;
			end
			CHAR_OPEN_CURLY: begin
				cls.op   = OP_PUSH;
				cls.kind = KIND_CURLY;
			end
			CHAR_CLOSE_ROUND: begin
				cls.op   = OP_POP;
				cls.kind = KIND_ROUND;
			end
			CHAR_CLOSE_SQUARE: begin
				cls.op   = OP_POP;
				cls.kind = KIND_SQUARE;
			end
			CHAR_CLOSE_CURLY: begin
				cls.op   = OP_POP;
				cls.kind = KIND_CURLY;
			end
			default: begin
				cls.op = OP_NONE;
			end
		endcase
	end

	assign req_ready = (cnt_q != (QPW+1)'(QDEPTH));
	assign q_valid   = (cnt_q != '0);
	assign q_data    = slot_q[rptr_q];
	assign wr_en     = req_valid && req_ready;
	assign rd_en     = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/bbc_back.sv */
`default_nettype none
module bbc_back #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire bbc_pkg::op_item_t q_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output bbc_pkg::out_item_t     rsp_data
);
	import bbc_pkg::*;

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [LW-1:0] level_q, level_n;
	status_t       err_q, err_n;
	kind_t         top_q, top_n;
	logic          byp_q;
	kind_t         byp_data_q;
	logic          rsp_valid_q;
	out_item_t     rsp_data_q;

	logic          adv;
	logic          we;
	logic [LW-1:0] wlevel;
	logic [LW-1:0] rlevel;
	logic [1:0]    rdata;
	kind_t         below;
	status_t       verdict;

	// a result can leave only when the output slot is free or draining
	assign adv     = q_valid && (!q_data.last || !rsp_valid_q || rsp_ready);
	assign q_ready = adv;

	// entry under the top: forwarded when the last accepted item pushed onto it
	assign below = byp_q ? byp_data_q : kind_t'(rdata);

	always_comb begin
		level_n = level_q;
		err_n   = err_q;
		top_n   = top_q;
		we      = 1'b0;
		verdict = STATUS_OK;
		if (adv) begin
			if (err_q == STATUS_OK) begin
				case (q_data.op)
					OP_PUSH: begin
						if (level_q == LW'(STACK_DEPTH)) begin
							err_n = STATUS_OVERFLOW;
						end else begin
							we      = (level_q != '0);
							top_n   = q_data.kind;
							level_n = level_q + 1'b1;
						end
					end
					OP_POP: begin
						if (level_q == '0 || top_q != q_data.kind) begin
							err_n = STATUS_MISMATCH;
						end else begin
							top_n   = below;
							level_n = level_q - 1'b1;
						end
					end
					default: begin
						level_n = level_q;
					end
				endcase
			end
			if (q_data.last) begin
				if (err_n != STATUS_OK) begin
					verdict = err_n;
				end else if (level_n != '0) begin
					verdict = STATUS_UNCLOSED;
				end else begin
					verdict = STATUS_OK;
				end
				level_n = '0;
				err_n   = STATUS_OK;
			end
		end
	end

	assign wlevel = level_q - 1'b1;
	assign rlevel = level_n - LW'(2);

	bbc_ram #(
		.WIDTH (2),
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (wlevel[AW-1:0]),
		.wdata (top_q),
		.raddr (rlevel[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		top_q <= top_n;
		if (adv) begin
			byp_data_q <= top_q;
		end
		if (adv && q_data.last) begin
			rsp_data_q.is_valid <= (verdict == STATUS_OK);
			rsp_data_q.status   <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			err_q       <= STATUS_OK;
			byp_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			level_q <= level_n;
			err_q   <= err_n;
			if (adv) begin
				byp_q <= we;
			end
			if (adv && q_data.last) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule
`default_nettype wire

/* sv/bbc_checker.sv */
`default_nettype none
module bbc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire bbc_pkg::in_item_t  req_data,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire bbc_pkg::out_item_t rsp_data
);
	import bbc_pkg::*;

	// a stalled verdict holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("verdict dropped or changed while stalled");

	// valid flag agrees with status
	a_verdict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.is_valid == (rsp_data.status == STATUS_OK)))
		else $error("is_valid disagrees with status");

	// nothing comes out in the first cycle after reset
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !rsp_valid)
		else $error("verdict right after reset");

	// a stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req_data))
		else $error("request dropped or changed while stalled");

endmodule

bind bracket_balance_checker_core bbc_checker u_bbc_checker (.*);
`default_nettype wire

/* bench/tb_bracket_balance_checker_core.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_bracket_balance_checker_core;
	import bbc_pkg::*;

	// no idling once this few requests remain
	localparam int TAIL_ITEMS   = 100;
	// requests to queue before stopping
	localparam int TARGET_ITEMS = 900;
	// long receiver hold-off, started once this many verdicts were checked
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [7:0] BRACKETS [6] = '{CHAR_OPEN_ROUND, CHAR_OPEN_SQUARE,
		CHAR_OPEN_CURLY, CHAR_CLOSE_ROUND, CHAR_CLOSE_SQUARE, CHAR_CLOSE_CURLY};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_item_t  req_data  = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp_data;

	// requests waiting to be driven, characters of the string being built
	in_item_t   pend_q[$];
	logic [7:0] str_q[$];
	int         queued_items;

	// predicted state: nesting stack, its level and the first error of the string
	kind_t      nest_kinds [STACK_DEPTH_DEF];
	int         nest_level;
	status_t    first_error;
	out_item_t  verdict_q[$];

	int errors;
	int gap_left, calm_reqs;
	int stall_left, calm_rsps;
	int verdicts_seen;
	int hold_left;
	bit hold_done;

	bracket_balance_checker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor: follows one accepted character, queues the verdict
	// ---------------------------------------------------------------
	task automatic scan_char(input in_item_t it);
		bit        is_open, is_close;
		kind_t     kind;
		out_item_t v;
		is_open  = 1'b0;
		is_close = 1'b0;
		kind     = KIND_ROUND;
		case (it.char_code)
			CHAR_OPEN_ROUND: begin
				is_open = 1'b1;
				kind = KIND_ROUND;
			end
			CHAR_OPEN_SQUARE: begin
				is_open = 1'b1;
				kind = KIND_SQUARE;
			end
			CHAR_OPEN_CURLY: begin
				is_open = 1'b1;
				kind = KIND_CURLY;
			end
			CHAR_CLOSE_ROUND: begin
				is_close = 1'b1;
				kind = KIND_ROUND;
			end
			CHAR_CLOSE_SQUARE: begin
				is_close = 1'b1;
				kind = KIND_SQUARE;
			end
			CHAR_CLOSE_CURLY: begin
				is_close = 1'b1;
				kind = KIND_CURLY;
			end
			default: ;
		endcase
		// once an error is recorded the rest of the string is ignored
		if (first_error == STATUS_OK) begin
			if (is_open) begin
				if (nest_level >= STACK_DEPTH_DEF) begin
					first_error = STATUS_OVERFLOW;
				end else begin
					nest_kinds[nest_level] = kind;
					nest_level++;
				end
			end else if (is_close) begin
				if (nest_level == 0 || nest_kinds[nest_level - 1] != kind) begin
					first_error = STATUS_MISMATCH;
				end else begin
					nest_level--;
				end
			end
		end
		if (it.last_of_string) begin
			if (first_error != STATUS_OK)
				v.status = first_error;
			else if (nest_level != 0)
				v.status = STATUS_UNCLOSED;
			else
				v.status = STATUS_OK;
			v.is_valid = (v.status == STATUS_OK);
			verdict_q.push_back(v);
			nest_level  = 0;
			first_error = STATUS_OK;
		end
	endtask

	// ---------------------------------------------------------------
	// string builders
	// ---------------------------------------------------------------
	function automatic bit is_bracket(input logic [7:0] c);
		foreach (BRACKETS[i])
			if (c == BRACKETS[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [7:0] open_char(input kind_t k);
		return BRACKETS[k];
	endfunction

	function automatic logic [7:0] close_char(input kind_t k);
		return BRACKETS[k + 3];
	endfunction

	// any byte that is not a bracket
	function automatic logic [7:0] filler_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (is_bracket(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// moves the built string into the request queue, flag on its last character
	task automatic close_string();
		in_item_t it;
		if (str_q.size() == 0)
			str_q.push_back(filler_char());
		foreach (str_q[i]) begin
			it.char_code      = str_q[i];
			it.last_of_string = (i == str_q.size() - 1);
			queued_items++;
			pend_q.push_back(it);
		end
		str_q.delete();
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			str_q.push_back(s[i]);
		close_string();
	endtask

	// properly nested brackets with fillers, not yet closed as a string
	task automatic build_nested(input int n_ops, input int max_d);
		kind_t stk[$];
		kind_t k;
		int    r;
		for (int i = 0; i < n_ops; i++) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				str_q.push_back(filler_char());
			end else if (stk.size() < max_d && (stk.size() == 0 || r < 7)) begin
				k = kind_t'($urandom_range(0, 2));
				stk.push_back(k);
				str_q.push_back(open_char(k));
			end else begin
				str_q.push_back(close_char(stk.pop_back()));
			end
		end
		while (stk.size() > 0)
			str_q.push_back(close_char(stk.pop_back()));
	endtask

	// nesting just below, at or past the stack depth, then unwound, at times without its final close
	task automatic build_deep();
		kind_t stk[$];
		kind_t k;
		int    n;
		case ($urandom_range(0, 3))
			0: n = STACK_DEPTH_DEF - 1;
			1: n = STACK_DEPTH_DEF;
			2: n = STACK_DEPTH_DEF + 1;
			default: n = STACK_DEPTH_DEF + $urandom_range(2, 5);
		endcase
		for (int i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(0, 2));
			stk.push_back(k);
			str_q.push_back(open_char(k));
			if ($urandom_range(0, 15) == 0)
				str_q.push_back(filler_char());
		end
		while (stk.size() > 0)
			str_q.push_back(close_char(stk.pop_back()));
		if ($urandom_range(0, 2) == 0)
			void'(str_q.pop_back());
	endtask

	// one broken spot: a swapped bracket, a dropped character or a stray close
	task automatic break_string();
		case ($urandom_range(0, 2))
			0: str_q[$urandom_range(0, str_q.size() - 1)] = BRACKETS[$urandom_range(0, 5)];
			1: if (str_q.size() > 1)
				str_q.delete($urandom_range(0, str_q.size() - 1));
			default: str_q.insert($urandom_range(0, str_q.size()), BRACKETS[$urandom_range(3, 5)]);
		endcase
	endtask

	// ---------------------------------------------------------------
	// driver: offers requests, holds each one until accepted
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
			gap_left  = 0;
			calm_reqs = 0;
		end else begin : drive
			logic offer;
			if (req_valid && req_ready)
				scan_char(req_data);
			// free to move on unless a request is still waiting
			if (!req_valid || req_ready) begin
				offer = 1'b0;
				if (calm_reqs == 0 && $urandom_range(0, 149) == 0)
					calm_reqs = 40;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() == 0) begin
					offer = 1'b0;
				end else if (calm_reqs == 0 && pend_q.size() > TAIL_ITEMS &&
						$urandom_range(0, 5) == 0) begin
					// idle burst, this cycle included
					gap_left = $urandom_range(0, 3);
				end else begin
					offer = 1'b1;
					if (calm_reqs > 0)
						calm_reqs--;
					req_data <= pend_q.pop_front();
				end
				req_valid <= offer;
			end
		end
	end

	// long hold-off on the verdict side, counted here on its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && verdicts_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ---------------------------------------------------------------
	// monitor: takes verdicts and checks them against the predictor
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready     <= 1'b0;
			verdicts_seen <= 0;
			stall_left    = 0;
			calm_rsps     = 0;
		end else begin : observe
			out_item_t exp_v;
			logic      take;
			if (rsp_valid && rsp_ready) begin
				verdicts_seen <= verdicts_seen + 1;
				if (verdict_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected verdict is_valid=%0b status=%0d",
						$time, rsp_data.is_valid, rsp_data.status);
				end else begin
					exp_v = verdict_q.pop_front();
					if (rsp_data.is_valid !== exp_v.is_valid) begin
						errors++;
						$display("%0t: is_valid expected %0b actual %0b",
							$time, exp_v.is_valid, rsp_data.is_valid);
					end
					if (rsp_data.status !== exp_v.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, exp_v.status, rsp_data.status);
					end
				end
			end
			take = 1'b1;
			if (calm_rsps == 0 && $urandom_range(0, 99) == 0)
				calm_rsps = 30;
			if (hold_left > 0) begin
				take = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else if (calm_rsps > 0) begin
				calm_rsps--;
			end else if (pend_q.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				take = 1'b0;
			end
			rsp_ready <= take;
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		int r;
		errors        = 0;
		queued_items  = 0;
		nest_level    = 0;
		first_error   = STATUS_OK;

		// directed: plain pairs, all kinds, lone extreme bytes, close on empty,
		// error kept over later characters, unclosed opens, fillers around brackets
		queue_text("()");
		queue_text("[{}]");
		str_q.push_back(8'h00);
		close_string();
		str_q.push_back(8'hff);
		close_string();
		queue_text(")");
		queue_text("(]}(");
		queue_text("{(a");
		queue_text("x(y)z");

		// random strings: mostly nested, some broken, some noise, a few at full depth
		while (queued_items < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				build_deep();
			end else if (r < 13) begin
				repeat ($urandom_range(1, 8))
					str_q.push_back($urandom_range(0, 1) ? BRACKETS[$urandom_range(0, 5)]
						: 8'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 9) == 0)
					build_nested($urandom_range(8, 40), $urandom_range(8, 24));
				else
					build_nested($urandom_range(1, 12), $urandom_range(1, 5));
				if ($urandom_range(0, 9) < 3)
					break_string();
			end
			close_string();
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || req_valid)
			@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		// leave room for anything stray
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_front.sv
sv/bbc_back.sv
sv/bracket_balance_checker_core.sv
sv/bbc_checker.sv
bench/tb_bracket_balance_checker_core.sv
